// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RNG block's RTL files.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== sv/xsr_pkg.sv =====
// Package for the xorshift* bounded RNG: constants, types, helper functions.
// No dependencies.
`default_nettype none
package xsr_pkg;
  localparam logic [63:0] SCRAMBLER  = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] FALLBACK   = 64'hD1B54A32D192ED03;
  localparam logic [63:0] OUT_MULT   = 64'h2545F4914F6CDD1D;
  localparam logic [63:0] MIX_MULT_A = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_MULT_B = 64'h94D049BB133111EB;
  localparam logic [62:0] COUNT_MAX  = {63{1'b1}};

  typedef enum logic [1:0] {
    REQ_DRAW64 = 2'd0,
    REQ_DRAW32 = 2'd1,
    REQ_BOUNDED = 2'd2,
    REQ_FORK = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DRAW, ST_MUL, ST_THR, ST_THR_WAIT, ST_BDRAW, ST_BMUL, ST_MOD,
    ST_MOD_WAIT, ST_FMUL_A, ST_FMUL_B, ST_OUT
  } state_t;

  // Multiplier request from the sequencer to the shared unit.
  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [32:0] den;
  } div_req_t;

  function automatic logic [63:0] xorshift(input logic [63:0] s);
    logic [63:0] v;
    v = s ^ (s >> 12);
    v = v ^ (v << 25);
    v = v ^ (v >> 27);
    return v;
  endfunction
endpackage
`default_nettype wire

// ===== sv/xsr_mul.sv =====
// Shared 64x64 -> low 64 multiplier, three 32x32 partial products over cycles.
// Depends on xsr_pkg.
`default_nettype none
`include "assert_macros.svh"
module xsr_mul (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire xsr_pkg::mul_req_t req,
  output logic                  done,
  output logic [63:0]           prod
);
  import xsr_pkg::*;
  logic [63:0] a, b, acc;
  logic [1:0]  step;
  logic        busy;
  logic [63:0] pp;
  logic [31:0] opa, opb;

  // Step 0: al*bl, step 1: ah*bl, step 2: al*bh (the high*high term drops out).
  always_comb begin
    opa = (step == 2'd1) ? a[63:32] : a[31:0];
    opb = (step == 2'd2) ? b[63:32] : b[31:0];
  end
  always_ff @(posedge clk) pp <= 64'(opa) * 64'(opb);

  logic [1:0] pstep;
  logic       pvalid;
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= 2'd0;
      pvalid <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      pvalid <= busy;
      pstep <= step;
      if (req.start) begin
        a <= req.a;
        b <= req.b;
        busy <= 1'b1;
        step <= 2'd0;
      end else if (busy) begin
        if (step == 2'd2) busy <= 1'b0;
        else step <= step + 2'd1;
      end
      if (pvalid) begin
        case (pstep)
          2'd0: acc <= pp;
          2'd1: acc <= acc + {pp[31:0], 32'd0};
          default: begin
            prod <= acc + {pp[31:0], 32'd0};
            done <= 1'b1;
          end
        endcase
      end
    end
  end

  `ASSERT_CLK(a_mul_done_once, clk, rst, done |=> !done)
  `ASSERT_CLK(a_mul_start_idle, clk, rst, req.start |-> !busy)
  `ASSERT_CLK(a_mul_step, clk, rst, busy |-> step != 2'd3)
endmodule
`default_nettype wire

// ===== sv/xsr_div.sv =====
// Restoring remainder unit: 64-bit dividend mod 33-bit divisor, one bit a cycle.
// Depends on xsr_pkg.
`default_nettype none
`include "assert_macros.svh"
module xsr_div (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire xsr_pkg::div_req_t req,
  output logic                  done,
  output logic [32:0]           rem
);
  import xsr_pkg::*;
  logic [63:0] num;
  logic [32:0] den;
  logic [6:0]  cnt;
  logic        busy;
  logic [33:0] trial;
  logic [33:0] shifted;

  always_comb begin
    shifted = {rem, num[63]};
    trial = shifted - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        num <= req.num;
        den <= req.den;
        rem <= '0;
        cnt <= 7'd0;
        busy <= 1'b1;
      end else if (busy) begin
        num <= {num[62:0], 1'b0};
        rem <= trial[33] ? shifted[32:0] : trial[32:0];
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  `ASSERT_CLK(a_div_done_once, clk, rst, done |=> !done)
  `ASSERT_CLK(a_div_start_idle, clk, rst, req.start |-> !busy)
  `ASSERT_CLK(a_div_rem_lt, clk, rst, done |-> rem < den)
endmodule
`default_nettype wire

// ===== sv/xorshift_star_bounded_rng.sv =====
// Top level of the xorshift64* RNG with rejection-sampled bounded integers.
// Depends on xsr_pkg, xsr_mul, xsr_div.
//
// Channel   Dir  Handshake           Payload
// s_axis    in   tvalid/tready       tuser: req_type; tdata: range_min, range_max, salt
// m_axis    out  tvalid/tready       tdata: raw_value, int_value, draws_done; tuser: valid_res
// seed      in   seed_we             seed (64-bit, unsigned)
//
// One item at a time. A 64- or 32-bit draw takes one pass of the shared multiplier,
// a fork two passes, and a bounded integer two passes of the shared remainder unit
// (threshold, then modulo) plus one multiplier pass per draw, rejected draws included.
// Reset loads the state from seed zero; a result waits in its output register
// until taken, and the next item is accepted at the same edge. Output stalls hold
// off the next accept.
`default_nettype none
`include "assert_macros.svh"
module xorshift_star_bounded_rng (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          seed_we,
  input  wire logic [63:0]   seed,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // req_type[1:0]
  input  wire logic [1:0]    s_axis_tuser,
  // range_min[31:0], range_max[63:32], salt[127:64]
  input  wire logic [127:0]  s_axis_tdata,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // raw_value[63:0], int_value[95:64], draws_done[158:96], zero pad
  output logic [159:0]       m_axis_tdata,
  // valid_res[0]
  output logic               m_axis_tuser
);
  import xsr_pkg::*;

  state_t      st, st_next;
  logic [63:0] rng_state;
  logic [62:0] draw_count;
  logic [1:0]  req;
  logic [31:0] lo;
  logic [32:0] width;
  logic [63:0] work;
  logic [32:0] thresh;
  logic [63:0] raw_r;
  logic [31:0] ival_r;
  logic        out_valid;

  mul_req_t    mreq;
  div_req_t    dreq;
  logic        mdone, ddone;
  logic [63:0] mprod;
  logic [32:0] drem;

  xsr_mul u_mul (.clk, .rst, .req(mreq), .done(mdone), .prod(mprod));
  xsr_div u_div (.clk, .rst, .req(dreq), .done(ddone), .rem(drem));

  logic        accept;
  logic signed [31:0] in_min, in_max;
  logic [32:0] span_up, span_down;
  logic [63:0] mixed;
  logic [63:0] nstate;

  assign s_axis_tready = (st == ST_IDLE) && (!out_valid || m_axis_tready);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign in_min = s_axis_tdata[31:0];
  assign in_max = s_axis_tdata[63:32];
  // Differences of the sign-extended bounds; one of them is the nonnegative span.
  assign span_up = {in_max[31], in_max} - {in_min[31], in_min};
  assign span_down = {in_min[31], in_min} - {in_max[31], in_max};
  assign nstate = xorshift(rng_state);
  assign mixed = rng_state ^ s_axis_tdata[127:64] ^ FALLBACK;

  always_ff @(posedge clk) begin
    if (rst) st <= ST_IDLE;
    else st <= st_next;
  end

  always_comb begin
    st_next = st;
    mreq = '{start: 1'b0, a: work, b: OUT_MULT};
    dreq = '{start: 1'b0, num: work, den: width};
    case (st)
      ST_IDLE: if (accept) begin
        case (req_t'(s_axis_tuser))
          REQ_BOUNDED: st_next = ST_THR;
          REQ_FORK: st_next = ST_FMUL_A;
          default: st_next = ST_DRAW;
        endcase
      end
      ST_DRAW: begin
        mreq.start = 1'b1;
        mreq.a = nstate;
        st_next = ST_MUL;
      end
      ST_MUL: if (mdone) st_next = ST_IDLE;
      ST_THR: begin
        dreq.start = 1'b1;
        dreq.num = 64'd0 - {31'd0, width};
        st_next = ST_THR_WAIT;
      end
      ST_THR_WAIT: if (ddone) st_next = ST_BDRAW;
      ST_BDRAW: begin
        mreq.start = 1'b1;
        mreq.a = nstate;
        st_next = ST_BMUL;
      end
      ST_BMUL: if (mdone) begin
        if (mprod < {31'd0, thresh}) st_next = ST_BDRAW;
        else st_next = ST_MOD;
      end
      ST_MOD: begin
        dreq.start = 1'b1;
        st_next = ST_MOD_WAIT;
      end
      ST_MOD_WAIT: if (ddone) st_next = ST_IDLE;
      ST_FMUL_A: begin
        mreq.start = 1'b1;
        mreq.a = work ^ (work >> 30);
        mreq.b = MIX_MULT_A;
        st_next = ST_FMUL_B;
      end
      ST_FMUL_B: if (mdone) begin
        mreq.start = 1'b1;
        mreq.a = mprod ^ (mprod >> 27);
        mreq.b = MIX_MULT_B;
        st_next = ST_OUT;
      end
      ST_OUT: if (mdone) st_next = ST_IDLE;
      default: st_next = ST_IDLE;
    endcase
  end

  // The fork's second product is finished in ST_OUT.
  always_ff @(posedge clk) begin
    if (rst) begin
      rng_state <= SCRAMBLER;
      draw_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && m_axis_tready) out_valid <= 1'b0;
      if (seed_we) begin
        rng_state <= ((seed ^ SCRAMBLER) == 64'd0) ? FALLBACK : (seed ^ SCRAMBLER);
        draw_count <= '0;
      end else if (st == ST_DRAW || st == ST_BDRAW) begin
        rng_state <= nstate;
        if (draw_count != COUNT_MAX) draw_count <= draw_count + 63'd1;
      end
      case (st)
        ST_IDLE: if (accept) begin
          req <= s_axis_tuser;
          work <= mixed;
          if (in_min > in_max) begin
            lo <= in_max;
            width <= span_down + 33'd1;
          end else begin
            lo <= in_min;
            width <= span_up + 33'd1;
          end
        end
        ST_DRAW, ST_BDRAW: work <= nstate;
        ST_THR_WAIT: if (ddone) thresh <= drem;
        ST_BMUL: if (mdone) work <= mprod;
        ST_MUL: if (mdone) begin
          raw_r <= (req == REQ_DRAW32) ? {32'd0, mprod[63:32]} : mprod;
          ival_r <= '0;
          out_valid <= 1'b1;
        end
        ST_MOD_WAIT: if (ddone) begin
          raw_r <= '0;
          ival_r <= lo + drem[31:0];
          out_valid <= 1'b1;
        end
        ST_OUT: if (mdone) begin
          raw_r <= mprod ^ (mprod >> 31);
          ival_r <= '0;
          out_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid && (st == ST_IDLE);
  assign m_axis_tdata = {1'b0, draw_count, ival_r, raw_r};
  assign m_axis_tuser = (rng_state != 64'd0) && (draw_count != COUNT_MAX);

  `ASSERT_CLK(a_state_nonzero, clk, rst, rng_state != 64'd0)
  `ASSERT_CLK(a_no_accept_busy, clk, rst, (st != ST_IDLE) |-> !s_axis_tready)
  `ASSERT_CLK(a_out_hold, clk, rst,
              (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
  `ASSERT_CLK(a_width_nonzero, clk, rst, (st == ST_THR) |-> width != 33'd0)
endmodule
`default_nettype wire
